### hw/rtl/ccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ccw_pkg;

    // Largest target the row covers
    localparam int MAX_AMOUNT = 1024;
    localparam int DEPTH      = MAX_AMOUNT + 1;
    localparam int ADDR_W     = $clog2(DEPTH);

    // Fixed field widths
    localparam int COIN_W = 11;
    localparam int TGT_W  = 11;
    localparam int CNT_W  = 64;

endpackage

`default_nettype wire

### hw/rtl/ccw_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Coin items in
interface ccw_in_if;
    logic                       valid;
    logic                       ready;
    logic [ccw_pkg::COIN_W-1:0] coin_value;
    logic                       last_coin;

    modport source (output valid, output coin_value, output last_coin, input ready);
    modport sink   (input valid, input coin_value, input last_coin, output ready);
endinterface

// Result items out
interface ccw_out_if;
    logic                      valid;
    logic                      ready;
    logic [ccw_pkg::CNT_W-1:0] way_count;
    logic                      overflow;
    logic                      is_final;

    modport source (output valid, output way_count, output overflow, output is_final,
                    input ready);
    modport sink   (input valid, input way_count, input overflow, input is_final,
                    output ready);
endinterface

// Target register write
interface ccw_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [ccw_pkg::TGT_W-1:0] target_amount;

    modport source (output valid, output target_amount, input ready);
    modport sink   (input valid, input target_amount, output ready);
endinterface

`default_nettype wire

### hw/rtl/ccw_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// One write port, two registered read ports, read returns old data on collision
module ccw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1025
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

### hw/rtl/ccw_sat_adder.sv
`timescale 1ns / 1ps
`default_nettype none

// Saturating add, flags a clamp
module ccw_sat_adder (
    input  wire logic [ccw_pkg::CNT_W-1:0] i_a,
    input  wire logic [ccw_pkg::CNT_W-1:0] i_b,
    output logic      [ccw_pkg::CNT_W-1:0] o_sum,
    output logic                           o_sat
);

    logic [ccw_pkg::CNT_W:0] full_sum;

    assign full_sum = {1'b0, i_a} + {1'b0, i_b};
    assign o_sat    = full_sum[ccw_pkg::CNT_W];
    assign o_sum    = o_sat ? {ccw_pkg::CNT_W{1'b1}} : full_sum[ccw_pkg::CNT_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/coin_change_way_counter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   coin_value[10:0], last_coin
// o_out     out  valid/ready   way_count[63:0], overflow, is_final
// i_cfg     in   valid/ready   target_amount[10:0] (ready always high)
//
// A coin c with 0 < c <= target walks the row once, one read-add-write per cycle;
// other coins only read row[target] before their result is loaded.
// A coin marked last adds a clearing pass over all MAX_AMOUNT+1 (1025) row entries after its
// result is loaded; the same pass runs straight after reset. i_in.ready is low meanwhile.
// The result register lets the next item start while a result waits; a held result
// stalls only the loading of the following one.
module coin_change_way_counter (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ccw_in_if.sink    i_in,
    ccw_out_if.source o_out,
    ccw_cfg_if.sink   i_cfg
);

    localparam int AW = ccw_pkg::ADDR_W;
    localparam int CW = ccw_pkg::CNT_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CLEAR = 6'b000010,
        S_PASS  = 6'b000100,  // issue reads for j and j-c, write j-1 result
        S_FLUSH = 6'b001000,  // last write of the pass
        S_RDT   = 6'b010000,  // read row[target]
        S_OUT   = 6'b100000   // load result register
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration
    logic [ccw_pkg::TGT_W-1:0] r_target;

    // Item context
    logic [AW-1:0] r_coin;
    logic [AW-1:0] r_tgt;
    logic          r_last;

    // Walk pointers and pipeline marks
    logic [AW-1:0] r_ja;       // upper read address, j
    logic [AW-1:0] r_jb;       // lower read address, j - c
    logic [AW-1:0] r_wa;       // address whose read data is back
    logic          r_pv;       // read data valid for r_wa
    logic          r_wrote;    // a row write went in last cycle
    logic [CW-1:0] r_last_sum;
    logic          r_sat;
    logic [AW-1:0] r_clr;

    // Result register
    logic          r_out_valid;
    logic [CW-1:0] r_way;
    logic          r_ovf;
    logic          r_fin;

    // Row RAM and adder
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr_a;
    logic [CW-1:0] ram_rdata_a;
    logic [CW-1:0] ram_rdata_b;
    logic [CW-1:0] b_op;
    logic [CW-1:0] add_sum;
    logic          add_sat;
    logic          do_wr;
    logic          in_take;
    logic [AW-1:0] tgt_eff;
    logic          walk;
    logic          out_free;

    ccw_ram #(
        .WIDTH (CW),
        .DEPTH (ccw_pkg::DEPTH)
    ) u_row (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (ram_raddr_a),
        .o_rdata_a (ram_rdata_a),
        .i_raddr_b (r_jb),
        .o_rdata_b (ram_rdata_b)
    );

    ccw_sat_adder u_add (
        .i_a   (ram_rdata_a),
        .i_b   (b_op),
        .o_sum (add_sum),
        .o_sat (add_sat)
    );

    // Target above the row length clamps to the top entry
    assign tgt_eff = (32'(r_target) > ccw_pkg::MAX_AMOUNT) ? AW'(ccw_pkg::MAX_AMOUNT)
                                                           : AW'(r_target);

    // Zero coin and coin above target leave the row alone
    assign walk = (32'(i_in.coin_value) != 0) &&
                  (32'(i_in.coin_value) <= 32'(tgt_eff));

    assign in_take  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // With a unit coin, j-1 is written in the cycle j-1 is read: forward it
    assign b_op = ((r_coin == AW'(1)) && r_wrote) ? r_last_sum : ram_rdata_b;

    assign do_wr = ((r_state == S_PASS) || (r_state == S_FLUSH)) && r_pv;

    always_comb begin
        ram_we      = 1'b0;
        ram_waddr   = r_wa;
        ram_wdata   = add_sum;
        ram_raddr_a = r_tgt;
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = (r_clr == '0) ? CW'(1) : '0;
        end else if (do_wr) begin
            ram_we = 1'b1;
        end
        if (r_state == S_PASS) begin
            ram_raddr_a = r_ja;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = walk ? S_PASS : S_RDT;
                end
            end
            S_CLEAR: begin
                if (r_clr == AW'(ccw_pkg::MAX_AMOUNT)) begin
                    n_state = S_IDLE;
                end
            end
            S_PASS: begin
                if (r_ja == r_tgt) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_RDT;
            S_RDT:   n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = r_last ? S_CLEAR : S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_target    <= '0;
            r_clr       <= '0;
            r_sat       <= 1'b0;
            r_pv        <= 1'b0;
            r_wrote     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.valid) begin
                r_target <= i_cfg.target_amount;
            end

            r_wrote <= do_wr;
            if (do_wr) begin
                r_last_sum <= add_sum;
                if (add_sat) begin
                    r_sat <= 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_coin <= AW'(i_in.coin_value);
                        r_tgt  <= tgt_eff;
                        r_last <= i_in.last_coin;
                        r_ja   <= AW'(i_in.coin_value);
                        r_jb   <= '0;
                        r_pv   <= 1'b0;
                    end
                end
                S_CLEAR: begin
                    r_sat <= 1'b0;
                    if (r_clr == AW'(ccw_pkg::MAX_AMOUNT)) begin
                        r_clr <= '0;
                    end else begin
                        r_clr <= r_clr + AW'(1);
                    end
                end
                S_PASS: begin
                    r_wa <= r_ja;
                    r_pv <= 1'b1;
                    r_ja <= r_ja + AW'(1);
                    r_jb <= r_jb + AW'(1);
                end
                S_FLUSH: r_pv <= 1'b0;
                default: begin
                end
            endcase

            // Result register: cleared on take, reloaded from the row read
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
                r_way       <= ram_rdata_a;
                r_ovf       <= r_sat;
                r_fin       <= r_last;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.way_count = r_way;
    assign o_out.overflow  = r_ovf;
    assign o_out.is_final  = r_fin;

endmodule

`default_nettype wire

### test/ccw_checker.sv
`timescale 1ns / 1ps

// Watches the coin, result and target channels, keeps its own ways row and
// compares every result item with the oldest predicted one.
module ccw_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ccw_in_if         in_mon,
    ccw_out_if        out_mon,
    ccw_cfg_if        cfg_mon,
    output int        o_errors,
    output int        o_pending,
    output int        o_results,
    output int        o_saturated
);

    typedef struct packed {
        logic [ccw_pkg::CNT_W-1:0] way_count;
        logic                      overflow;
        logic                      is_final;
    } t_ways_result;

    logic [ccw_pkg::CNT_W-1:0] ways_row [0:ccw_pkg::MAX_AMOUNT];
    logic                      row_saturated;
    logic [ccw_pkg::TGT_W-1:0] target_reg;
    t_ways_result              expected_ways[$];

    function void clear_ways_row();
        for (int j = 0; j <= ccw_pkg::MAX_AMOUNT; j++) ways_row[j] = '0;
        ways_row[0]   = 64'd1;
        row_saturated = 1'b0;
    endfunction

    // One coin: rolling-row update up to the clamped target, then report.
    function t_ways_result tally_coin(input logic [ccw_pkg::COIN_W-1:0] coin,
                                      input logic last);
        int                      span;
        int                      c;
        logic [ccw_pkg::CNT_W:0] sum;
        t_ways_result            res;
        c    = int'(coin);
        span = (int'(target_reg) > ccw_pkg::MAX_AMOUNT) ? ccw_pkg::MAX_AMOUNT
                                                         : int'(target_reg);
        if (c != 0 && c <= span) begin
            for (int j = c; j <= span; j++) begin
                sum = {1'b0, ways_row[j]} + {1'b0, ways_row[j - c]};
                if (sum[ccw_pkg::CNT_W]) begin
                    row_saturated = 1'b1;
                    ways_row[j]   = '1;
                end else begin
                    ways_row[j] = sum[ccw_pkg::CNT_W-1:0];
                end
            end
        end
        res.way_count = ways_row[span];
        res.overflow  = row_saturated;
        res.is_final  = last;
        if (last) clear_ways_row();
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_ways_result got;
        t_ways_result want;
        t_ways_result fresh;
        if (!i_rst_n) begin
            clear_ways_row();
            target_reg = '0;
            expected_ways.delete();
        end else begin
            // A coin taken at this edge still sees the target held before it
            if (in_mon.valid && in_mon.ready) begin
                fresh = tally_coin(in_mon.coin_value, in_mon.last_coin);
                expected_ways.insert(expected_ways.size(), fresh);
            end
            if (cfg_mon.valid && cfg_mon.ready) target_reg = cfg_mon.target_amount;
            if (out_mon.valid && out_mon.ready) begin
                got.way_count = out_mon.way_count;
                got.overflow  = out_mon.overflow;
                got.is_final  = out_mon.is_final;
                o_results++;
                if (got.overflow === 1'b1) o_saturated++;
                if (expected_ways.size() == 0) begin
                    $display("%0d ns: result with nothing expected, expected none, %s",
                             $time, "got:");
                    $display("    %0d/%0b/%0b", got.way_count, got.overflow, got.is_final);
                    o_errors++;
                end else begin
                    want = expected_ways.pop_front();
                    if (got.way_count !== want.way_count) begin
                        $display("%0d ns: way_count mismatch, expected %0d, got %0d",
                                 $time, want.way_count, got.way_count);
                        o_errors++;
                    end
                    if (got.overflow !== want.overflow) begin
                        $display("%0d ns: overflow mismatch, expected %0b, got %0b",
                                 $time, want.overflow, got.overflow);
                        o_errors++;
                    end
                    if (got.is_final !== want.is_final) begin
                        $display("%0d ns: is_final mismatch, expected %0b, got %0b",
                                 $time, want.is_final, got.is_final);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = expected_ways.size();
    end

endmodule

### test/tb_coin_change_way_counter.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the coin change way counter. Prediction and
// comparison live in ccw_checker; this module only drives the channels.
module tb_coin_change_way_counter;

    localparam int     CLK_HALF     = 10;
    localparam int     RESET_CYCLES = 9;
    localparam int     RANDOM_ITEMS = 500;
    // clearing pass after a last coin (and after reset) plus some slack
    localparam int     ROW_SETTLE   = ccw_pkg::DEPTH + 32;
    localparam int     HOLD_CYCLES  = 300;
    // sized for worst-case items (full walk, clearing pass, both gaps)
    localparam longint CYCLE_LIMIT  = 10_000_000;

    typedef logic [ccw_pkg::COIN_W-1:0] t_coin;
    typedef logic [ccw_pkg::TGT_W-1:0]  t_tgt;

    logic   clk   = 1'b0;
    logic   rst_n = 1'b0;
    longint cycle_count = 0;

    // Knobs for the sender and the receiver process
    bit quiet_tx     = 1'b0;   // sender offers back to back
    bit quiet_rx     = 1'b0;   // receiver always ready
    bit hold_off_due = 1'b0;   // receiver to stall for HOLD_CYCLES

    int coins_sent      = 0;
    int random_coins    = 0;
    int sets_closed     = 0;
    int targets_written = 0;

    int chk_errors;
    int chk_pending;
    int chk_results;
    int chk_saturated;

    ccw_in_if  in_ch ();
    ccw_out_if out_ch ();
    ccw_cfg_if cfg_ch ();

    coin_change_way_counter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ccw_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .in_mon      (in_ch),
        .out_mon     (out_ch),
        .cfg_mon     (cfg_ch),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_results   (chk_results),
        .o_saturated (chk_saturated)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends up here
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers. Every task is entered and left at a falling edge,
    // with no assignment pending in that step.
    // ------------------------------------------------------------------

    // Offer one coin item after a random gap (none when quiet_tx), hold it until taken.
    task automatic push_coin(input logic [ccw_pkg::COIN_W-1:0] coin, input logic last);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.coin_value <= coin;
        in_ch.last_coin  <= last;
        in_ch.valid      <= 1'b1;
        @(posedge clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
        @(negedge clk);
        coins_sent++;
        if (last) sets_closed++;
    endtask

    // Pause the sender until every expected result is back, let a possible
    // clearing pass finish, then load a new target.
    task automatic set_target(input logic [ccw_pkg::TGT_W-1:0] value);
        in_ch.valid <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
        repeat (ROW_SETTLE) @(negedge clk);
        cfg_ch.target_amount <= value;
        cfg_ch.valid         <= 1'b1;
        @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        targets_written++;
    endtask

    // Coin mix: mostly in range, with zeros, oversize coins, tiny coins
    // (which drive the counts towards saturation) and raw field values.
    function automatic logic [ccw_pkg::COIN_W-1:0] pick_coin(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return t_coin'($urandom_range(0, 2047));
        if (r == 2 && span < 2047) return t_coin'($urandom_range(span + 1, 2047));
        if (r <= 4) return t_coin'($urandom_range(1, 3));
        if (span == 0) return t_coin'($urandom_range(1, 2047));
        return t_coin'($urandom_range(1, span));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random gap before each result item, quiet stretches, and
    // one long hold-off so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int low;
        out_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            low = quiet_rx ? 0 : $urandom_range(0, 9);
            if (hold_off_due) low = low + HOLD_CYCLES;
            if (low != 0) begin
                out_ch.ready <= 1'b0;
                repeat (low) @(negedge clk);
                hold_off_due = 1'b0;
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [ccw_pkg::TGT_W-1:0] tgt;
        int                        span;
        int                        pick;
        int                        n;
        in_ch.valid          = 1'b0;
        in_ch.coin_value     = '0;
        in_ch.last_coin      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.target_amount = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Target still at its reset value of 0: every coin is ignored,
        // the count stays at one (the empty combination).
        push_coin(11'd0, 1'b0);
        push_coin(11'd2047, 1'b0);
        push_coin(11'd1, 1'b1);

        // Small target: zero coin, coin above target, ordinary coins,
        // a coin equal to the target closing the set.
        set_target(11'd10);
        push_coin(11'd0, 1'b0);
        push_coin(11'd11, 1'b0);
        push_coin(11'd2, 1'b0);
        push_coin(11'd5, 1'b0);
        push_coin(11'd2047, 1'b0);
        push_coin(11'd1, 1'b0);
        push_coin(11'd10, 1'b1);

        // Target raised mid-set: the row is kept, entries above the old
        // target only see coins that arrive after the change.
        set_target(11'd4);
        push_coin(11'd1, 1'b0);
        set_target(11'd9);
        push_coin(11'd3, 1'b0);
        push_coin(11'd1, 1'b1);

        // Out-of-range target clamps to the full row; a coin equal to the
        // clamped target, then repeated unit coins push the counts past 64 bits.
        set_target(11'd2047);
        push_coin(11'd1024, 1'b0);
        for (int k = 0; k < 10; k++) push_coin(11'd1, k == 9);

        // Long receiver stall while the sender keeps pushing small coins
        set_target(11'd6);
        quiet_tx     = 1'b1;
        hold_off_due = 1'b1;
        for (int k = 0; k < 14; k++) begin
            push_coin(t_coin'($urandom_range(1, 6)), k == 13);
            random_coins++;
        end
        quiet_tx = 1'b0;

        // Random phases: a target per phase, mostly small so the walks stay
        // short, now and then a large or clamped one. Sets run across
        // phase boundaries, so mid-set target changes keep happening.
        while (random_coins < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick <= 1)      tgt = t_tgt'($urandom_range(1024, 2047));
            else if (pick == 2) tgt = t_tgt'($urandom_range(81, 1023));
            else                tgt = t_tgt'($urandom_range(0, 80));
            set_target(tgt);
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            span = (int'(tgt) > ccw_pkg::MAX_AMOUNT) ? ccw_pkg::MAX_AMOUNT : int'(tgt);
            n    = (span > 80) ? $urandom_range(2, 14) : $urandom_range(4, 24);
            repeat (n) begin
                push_coin(pick_coin(span), $urandom_range(0, 7) == 0);
                random_coins++;
            end
        end

        // Drain, then give the last clearing pass time to finish
        in_ch.valid <= 1'b0;
        while (chk_pending != 0) @(negedge clk);
        repeat (ROW_SETTLE) @(negedge clk);

        $display("Run: %0d coin items, %0d sets closed, %0d target loads incl. 0 and clamped.",
                 coins_sent, sets_closed, targets_written);
        $display("Run: %0d results checked, %0d flagged saturated; long stall and drains seen.",
                 chk_results, chk_saturated);
        if (chk_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
